@@ rtl/awc_pkg.sv @@
// Shared types, constants and constant functions of the waveshaping clipper.
`default_nettype none
package awc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF    = 20;

    // Internal precision of the tanh polynomial and of the arctangent angles.
    localparam int INNER_BITS   = 16;
    localparam int ANGLE_BITS   = 30;
    localparam int CORDIC_STEPS = 30;

    // round(2^30 * 2 / pi)
    localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;

    typedef enum logic [1:0] {
        MODE_SOFT  = 2'd0,
        MODE_CUBIC = 2'd1,
        MODE_TANH  = 2'd2,
        MODE_ATAN  = 2'd3
    } curve_mode_t;

    // atan(2^-i) * 2/pi with ANGLE_BITS fraction bits, evaluated at elaboration
    // from the arctangent series.
    function automatic logic [63:0] awc_angle(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        acc = 64'd0;
        if (i == 0)
        begin
            return 64'd1 << (ANGLE_BITS - 1);
        end
        for (int k = 0; k < 40; k++)
        begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0)
            begin
                term = (64'd1 << e) / 64'(2 * k + 1);
                if (k[0])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        return (((acc >> 28) * 64'(TWO_OVER_PI_Q30)) + (64'd1 << 31)) >> 32;
    endfunction

endpackage
`default_nettype wire

@@ rtl/awc_div.sv @@
// Pipelined restoring divider producing one quotient bit per stage.
`default_nettype none
module awc_div
    import awc_pkg::*;
#(
    parameter int DW = 56,
    parameter int QW = 22
)(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] r_reg [0:QW-2];
    logic [DW-1:0] d_reg [0:QW-2];
    logic [QW-1:0] q_reg [0:QW-1];

    // The first stage takes the integer bit; the numerator is below twice the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (num >= den)
            begin
                r_reg[0] <= num - den;
                q_reg[0] <= QW'(1);
            end
            else
            begin
                r_reg[0] <= num;
                q_reg[0] <= '0;
            end
            d_reg[0] <= den;
        end
    end

    for (genvar j = 1; j < QW; j++)
    begin : g_step
        logic [DW:0] rs;
        logic        ge;
        assign rs = {r_reg[j-1], 1'b0};
        assign ge = (rs >= {1'b0, d_reg[j-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j] <= {q_reg[j-1][QW-2:0], ge};
            end
        end

        if (j < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j] <= ge ? DW'(rs - {1'b0, d_reg[j-1]}) : DW'(rs);
                    d_reg[j] <= d_reg[j-1];
                end
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule
`default_nettype wire

@@ rtl/awc_cordic.sv @@
// Pipelined vectoring CORDIC giving (2/pi)*atan of a magnitude, rounded.
`default_nettype none
module awc_cordic
    import awc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   en,
    input  logic [SAMPLE_WIDTH-1:0] mag,
    output logic [FRAC_BITS:0]      angle
);

    localparam int HEAD  = (SAMPLE_WIDTH > FRAC_BITS) ? SAMPLE_WIDTH : FRAC_BITS + 1;
    localparam int SHIFT = 59 - HEAD;
    localparam int ZW    = ANGLE_BITS + 3;
    localparam int RSH   = ANGLE_BITS - FRAC_BITS;

    logic signed [63:0]   x_reg [0:CORDIC_STEPS];
    logic signed [63:0]   y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 zf_reg [0:CORDIC_STEPS];
    logic [FRAC_BITS:0]   angle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= 64'sd1 <<< (FRAC_BITS + SHIFT);
            y_reg[0]  <= $signed(64'(mag) << SHIFT);
            z_reg[0]  <= '0;
            zf_reg[0] <= (mag == '0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ANG = ZW'(awc_angle(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 64'sd0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                zf_reg[i+1] <= zf_reg[i];
            end
        end
    end

    // Clamp the angle sum to [0, 1.0] and round to the sample's fraction bits.
    logic [ANGLE_BITS:0] zc;
    logic [ANGLE_BITS:0] zr;
    always_comb
    begin
        if (z_reg[CORDIC_STEPS] < 0)
        begin
            zc = '0;
        end
        else if (z_reg[CORDIC_STEPS] > (ZW'(1) <<< ANGLE_BITS))
        begin
            zc = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
        end
        else
        begin
            zc = (ANGLE_BITS+1)'(z_reg[CORDIC_STEPS]);
        end
        zr = (zc + ((ANGLE_BITS+1)'(1) << (RSH - 1))) >> RSH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zf_reg[CORDIC_STEPS] ? '0 : (FRAC_BITS+1)'(zr);
        end
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

@@ rtl/audio_waveshaper_clipper.sv @@
// Top level of the waveshaping clipper: four odd transfer curves on a sample stream.
`default_nettype none
// The clipper takes one signed fixed-point sample per transfer and returns one
// shaped sample per transfer, in the same format, with no memory between
// samples. curve_mode picks the curve: soft rational 1.2*x/(|x|+1), cubic
// x - x^3/3 held at +-2/3 beyond |x| = 1, (2/pi)*tanh(x) by a 7/6 Pade ratio
// (input held at +-5.0), or (2/pi)*atan(x) by a 30-step CORDIC. Each curve
// shapes the magnitude and restores the sign, so rounding is symmetric about
// zero. The datapath is a single pipeline that takes a new sample in every
// cycle while the output is not stalled; its depth is set by the longer of
// the quotient-bit-per-stage divider chain and the CORDIC chain. A stall on the
// output freezes the whole pipeline in place, and s_axis_tready follows
// m_axis_tready combinationally. Write curve_mode only when the pipeline is empty.
module audio_waveshaper_clipper
    import awc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_in in the low SAMPLE_WIDTH bits, zero fill above
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sample_out in the low SAMPLE_WIDTH bits, zero fill above
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW  = (W > F + 3) ? W : F + 3;
    localparam int DW  = (2 * F + 3 > 56) ? 2 * F + 3 : 56;
    localparam int QW  = F + 2;
    localparam int MW  = F + 2;
    // Start offsets of the divider and CORDIC paths, and the stage where they meet.
    localparam int DST = (32 > F + 14) ? 32 - F - 14 : 0;
    localparam int AST = (F + 14 > 32) ? F + 14 - 32 : 0;
    localparam int PS  = DST + F + 14;
    localparam int MS  = PS + 1;
    localparam int CW  = ((MW > W) ? MW : W) + 1;

    localparam logic [AW-1:0] ONE      = AW'(1) << F;
    localparam logic [AW-1:0] FIVE_ONE = AW'(5) << F;
    localparam logic [MW-1:0] CUB_HOLD = MW'(((2 << F) + 1) / 3);
    localparam logic [CW-1:0] TOP      = (CW'(1) << (W - 1)) - CW'(1);
    localparam logic [DW-1:0] CUB_DEN  = DW'(3) << (2 * F);

    localparam logic [27:0] K3150   = 28'(3150) << INNER_BITS;
    localparam logic [24:0] K378    = 25'(378) << INNER_BITS;
    localparam logic [33:0] K62370  = 34'(62370) << INNER_BITS;
    localparam logic [30:0] K17325  = 31'(17325) << INNER_BITS;
    localparam logic [37:0] K135135 = 38'(135135) << INNER_BITS;
    localparam logic [35:0] N135135 = 36'(135135) << INNER_BITS;

    // ------------------------------------------------------------------
    // Control: one shared advance for every stage; it stops only while the
    // output register is full and the downstream ready is low.
    // ------------------------------------------------------------------
    curve_mode_t    curve_mode_reg;
    logic           vld_reg [0:MS];
    logic           out_valid_reg;
    logic [W-1:0]   out_reg;
    logic           adv;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDW'(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg <= MODE_SOFT;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k <= MS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                curve_mode_reg <= curve_mode_t'(cfg_wdata);
            end
            if (adv)
            begin
                vld_reg[0] <= s_axis_tvalid;
                for (int k = 1; k <= MS; k++)
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
                out_valid_reg <= vld_reg[MS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: split the sample into sign and magnitude, and carry both
    // along the pipeline for the later stages that need them.
    // ------------------------------------------------------------------
    logic [W-1:0]  x_in;
    logic [W-1:0]  a_in;
    logic [AW-1:0] a_pipe_reg [0:PS];
    logic          sign_pipe_reg [0:PS];

    assign x_in = s_axis_tdata[W-1:0];
    assign a_in = x_in[W-1] ? (~x_in + W'(1)) : x_in;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pipe_reg[0]    <= AW'(a_in);
            sign_pipe_reg[0] <= x_in[W-1];
            for (int k = 1; k <= PS; k++)
            begin
                a_pipe_reg[k]    <= a_pipe_reg[k-1];
                sign_pipe_reg[k] <= sign_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Tanh front end: clamp to 5.0, move to 16 fraction bits, then the two
    // Horner chains of the Pade ratio.
    // ------------------------------------------------------------------
    logic [AW-1:0] a5;
    logic [18:0]   b_next;

    assign a5 = (a_pipe_reg[DST] > FIVE_ONE) ? FIVE_ONE : a_pipe_reg[DST];

    if (F > INNER_BITS)
    begin : g_b_down
        localparam int SH = F - INNER_BITS;
        logic [F+3:0] b_sum;
        assign b_sum  = {1'b0, a5[F+2:0]} + ((F+4)'(1) << (SH - 1));
        assign b_next = 19'(b_sum >> SH);
    end
    else if (F == INNER_BITS)
    begin : g_b_same
        assign b_next = a5[18:0];
    end
    else
    begin : g_b_up
        assign b_next = 19'({a5[F+2:0], {(INNER_BITS - F){1'b0}}});
    end

    logic [18:0] b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg, b7_reg, b8_reg;
    logic [37:0] bb2_reg;
    logic [20:0] ts3_reg, ts4_reg, ts5_reg, ts6_reg;
    logic [27:0] d1_reg;
    logic [24:0] n1_reg;
    logic [48:0] pd5_reg;
    logic [45:0] pn5_reg;
    logic [33:0] d2_reg;
    logic [30:0] n2_reg;
    logic [54:0] pd7_reg;
    logic [51:0] pn7_reg;
    logic [37:0] d3_reg, d9_reg;
    logic [35:0] n3_reg;
    logic [54:0] nb9_reg;

    // Cubic front end: square, round, multiply by the magnitude again.
    logic [2*F+1:0] csq7_reg;
    logic [F:0]     cs8_reg;
    logic [2*F+1:0] cp9_reg;

    logic [2*F+2:0] csq_rnd;
    logic [49:0]    pd5_rnd;
    logic [46:0]    pn5_rnd;
    logic [55:0]    pd7_rnd;
    logic [52:0]    pn7_rnd;

    assign csq_rnd = {1'b0, csq7_reg} + ((2*F+3)'(1) << (F - 1));
    assign pd5_rnd = {1'b0, pd5_reg} + 50'h8000;
    assign pn5_rnd = {1'b0, pn5_reg} + 47'h8000;
    assign pd7_rnd = {1'b0, pd7_reg} + 56'h8000;
    assign pn7_rnd = {1'b0, pn7_reg} + 53'h8000;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg  <= b_next;
            bb2_reg <= 38'(b1_reg) * 38'(b1_reg);
            b2_reg  <= b1_reg;
            ts3_reg <= 21'((bb2_reg + 38'h8000) >> INNER_BITS);
            b3_reg  <= b2_reg;
            d1_reg  <= 28'(ts3_reg) * 28'd28 + K3150;
            n1_reg  <= 25'(ts3_reg) + K378;
            ts4_reg <= ts3_reg;
            b4_reg  <= b3_reg;
            pd5_reg <= 49'(d1_reg) * 49'(ts4_reg);
            pn5_reg <= 46'(n1_reg) * 46'(ts4_reg);
            ts5_reg <= ts4_reg;
            b5_reg  <= b4_reg;
            d2_reg  <= 34'(pd5_rnd >> INNER_BITS) + K62370;
            n2_reg  <= 31'(pn5_rnd >> INNER_BITS) + K17325;
            ts6_reg <= ts5_reg;
            b6_reg  <= b5_reg;
            pd7_reg <= 55'(d2_reg) * 55'(ts6_reg);
            pn7_reg <= 52'(n2_reg) * 52'(ts6_reg);
            b7_reg  <= b6_reg;
            d3_reg  <= 38'(pd7_rnd >> INNER_BITS) + K135135;
            n3_reg  <= 36'(pn7_rnd >> INNER_BITS) + N135135;
            b8_reg  <= b7_reg;
            nb9_reg <= 55'(n3_reg) * 55'(b8_reg);
            d9_reg  <= d3_reg;

            csq7_reg <= (2*F+2)'(a_pipe_reg[DST+6][F:0]) * (2*F+2)'(a_pipe_reg[DST+6][F:0]);
            cs8_reg  <= (F+1)'(csq_rnd >> F);
            cp9_reg  <= (2*F+2)'(cs8_reg) * (2*F+2)'(a_pipe_reg[DST+8][F:0]);
        end
    end

    // ------------------------------------------------------------------
    // Divider operands: every divider curve is round(num * 2^F / den).
    // The cubic case divides by 3 * 2^(2F) to get round(s*|x| / (3 * 2^F)).
    // ------------------------------------------------------------------
    logic [DW-1:0] num_next, den_next;
    logic [DW-1:0] div_num_reg, div_den_reg;
    logic [QW-1:0] quo;

    always_comb
    begin
        unique case (curve_mode_reg)
            MODE_CUBIC:
            begin
                num_next = DW'(cp9_reg);
                den_next = CUB_DEN;
            end
            MODE_TANH:
            begin
                num_next = DW'(nb9_reg);
                den_next = DW'(d9_reg) << INNER_BITS;
            end
            default:
            begin
                num_next = DW'(a_pipe_reg[DST+9]) * DW'(6);
                den_next = (DW'(a_pipe_reg[DST+9]) + DW'(ONE)) * DW'(5);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_num_reg <= num_next;
            div_den_reg <= den_next;
        end
    end

    awc_div #(
        .DW (DW),
        .QW (QW)
    ) u_div (
        .clk (clk),
        .en  (adv),
        .num (div_num_reg),
        .den (div_den_reg),
        .quo (quo)
    );

    // ------------------------------------------------------------------
    // Arctangent path, timed to land at the same stage as the tanh scaling.
    // ------------------------------------------------------------------
    logic [F:0] atan_m;

    awc_cordic #(
        .SAMPLE_WIDTH (W),
        .FRAC_BITS    (F)
    ) u_cordic (
        .clk   (clk),
        .en    (adv),
        .mag   (a_pipe_reg[AST][W-1:0]),
        .angle (atan_m)
    );

    // ------------------------------------------------------------------
    // Back end: round the quotient, scale tanh by 2/pi, pick the curve,
    // then saturate and restore the sign into the output register.
    // ------------------------------------------------------------------
    logic [MW-1:0]    t_reg, t2_reg;
    logic [MW+29:0]   tp_reg;
    logic [MW+30:0]   tp_rnd;
    logic [MW-1:0]    m_next, m_reg;
    logic             sign_m_reg;
    logic [CW-1:0]    m_ext, mag_pos, mag_neg;

    assign tp_rnd = {1'b0, tp_reg} + ((MW+31)'(1) << (ANGLE_BITS - 1));

    always_comb
    begin
        unique case (curve_mode_reg)
            MODE_SOFT:
            begin
                m_next = t2_reg;
            end
            MODE_CUBIC:
            begin
                if (a_pipe_reg[PS] > ONE)
                begin
                    m_next = CUB_HOLD;
                end
                else
                begin
                    m_next = MW'(a_pipe_reg[PS][F:0]) - t2_reg;
                end
            end
            MODE_TANH:
            begin
                m_next = MW'(tp_rnd >> ANGLE_BITS);
            end
            default:
            begin
                m_next = MW'(atan_m);
            end
        endcase
    end

    assign m_ext   = CW'(m_reg);
    assign mag_pos = (m_ext > TOP) ? TOP : m_ext;
    assign mag_neg = (m_ext > TOP + CW'(1)) ? TOP + CW'(1) : m_ext;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg      <= MW'(((QW+1)'(quo) + (QW+1)'(1)) >> 1);
            tp_reg     <= (MW+30)'(t_reg) * (MW+30)'(TWO_OVER_PI_Q30);
            t2_reg     <= t_reg;
            m_reg      <= m_next;
            sign_m_reg <= sign_pipe_reg[PS];
            out_reg    <= sign_m_reg ? W'(~mag_neg + CW'(1)) : W'(mag_pos);
        end
    end

endmodule
`default_nettype wire
